// ----- rtl/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the splat tile binner
// Field widths, register indexes and the stage function of the pipelined tile divider.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int FracBits      = 4;
  localparam int CoordW        = 17;
  localparam int PixW          = CoordW - 1 - FracBits;
  localparam int WidthW        = 13;
  localparam int HeightW       = 11;
  localparam int TsW           = 9;
  localparam int CfgDataW      = 13;
  localparam int CfgIdxW       = 2;
  localparam int IdW           = 32;
  localparam int RowW          = 6;
  localparam int ColW          = 8;
  localparam int MaxTileRows   = 64;
  localparam int MaxTileCols   = 256;
  localparam int RowCap        = (MaxTileRows < 64) ? MaxTileRows : 64;
  localparam int LastRowMax    = RowCap - 1;
  localparam int LastColMax    = MaxTileCols - 1;
  localparam int StepsPerStage = 3;
  localparam int DivStages     = PixW / StepsPerStage;
  localparam int Lanes         = 4;

  // Divider lanes: first and last tile column, first and last tile row.
  localparam int LaneFx = 0;
  localparam int LaneLx = 1;
  localparam int LaneFy = 2;
  localparam int LaneLy = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgTileSize    = 2'd2
  } cfg_index_e;

  // Partial remainder and a word that shifts dividend bits out on the left
  // while quotient bits come in on the right.
  typedef struct packed {
    logic [TsW-1:0]  rem;
    logic [PixW-1:0] work;
  } div_lane_t;

  // StepsPerStage steps of restoring division.
  function automatic div_lane_t div_step(div_lane_t cur, logic [TsW-1:0] divisor);
    div_lane_t  nxt;
    logic [TsW:0] trial;
    nxt = cur;
    for (int i = 0; i < StepsPerStage; i++) begin
      trial    = {nxt.rem, nxt.work[PixW-1]};
      nxt.work = {nxt.work[PixW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial       = trial - {1'b0, divisor};
        nxt.work[0] = 1'b1;
      end
      nxt.rem = trial[TsW-1:0];
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/splat_tile_binner_top.sv -----
// ----------------------------------------------------------------------------
// splat_tile_binner_top: bins splat bounding boxes into tile row spans
// Clips a fixed-point box to the image, divides by the tile size in a
// pipelined divider and emits one column span per covered tile row.
// ----------------------------------------------------------------------------
// Path: the first span of a box is presented once the box has passed stage 0,
// the divider stages and the emitter register; further rows come one per cycle
// while out_ready_i is high. Throughput: a box enters every cycle while the row
// emitter keeps up; the emitter holds a box until its last covered row is taken.
// Reset: the divider pipeline and the emitter empty out; the registers return
// to an image of 1024 x 1024 pixels with 16-pixel tiles.
module splat_tile_binner_top
  import stb_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  // Box input channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [CoordW-1:0]   box_min_x_i,
  input  logic signed [CoordW-1:0]   box_min_y_i,
  input  logic signed [CoordW-1:0]   box_max_x_i,
  input  logic signed [CoordW-1:0]   box_max_y_i,
  input  logic [IdW-1:0]             splat_id_i,
  // Row span output channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [RowW-1:0]            tile_row_o,
  output logic [ColW-1:0]            first_col_o,
  output logic [ColW-1:0]            last_col_o,
  output logic [IdW-1:0]             splat_out_o,
  output logic                       final_row_o
);

  // --------------------------------------------------------------------------
  // Configuration registers. The user must change them only while no box is
  // in flight; the block does not check. Every pipeline stage reads them directly.
  // --------------------------------------------------------------------------
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [TsW-1:0]     tile_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(1024);
      height_q <= HeightW'(1024);
      tile_q   <= TsW'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[HeightW-1:0];
        CfgTileSize:    tile_q   <= cfg_data_i[TsW-1:0];
        default:        ;
      endcase
    end
  end

  // A tile size of zero behaves as a single pixel.
  logic [TsW-1:0] divisor;
  assign divisor = (tile_q == '0) ? TsW'(1) : tile_q;

  // --------------------------------------------------------------------------
  // Clipping. The minimum corner is clamped at zero and the maximum corner at
  // the image edge. Dividing the fixed-point value by the tile size times
  // 2^FracBits equals dividing its whole-pixel part by the tile size, so only
  // the pixel bits enter the divider. The exclusive maximum becomes inclusive
  // by taking off one fraction LSB first.
  // --------------------------------------------------------------------------
  logic signed [CoordW:0]  w_fx, h_fx;
  logic signed [CoordW:0]  max_x_ext, max_y_ext;
  logic signed [CoordW:0]  max_x_c, max_y_c;
  logic signed [CoordW:0]  max_x_m1, max_y_m1;
  logic [CoordW-2:0]       min_x_c, min_y_c;
  logic                    box_live;

  assign w_fx = {1'b0, width_q, {FracBits{1'b0}}};
  assign h_fx = {{(CoordW + 1 - HeightW - FracBits){1'b0}}, height_q, {FracBits{1'b0}}};

  assign max_x_ext = {box_max_x_i[CoordW-1], box_max_x_i};
  assign max_y_ext = {box_max_y_i[CoordW-1], box_max_y_i};
  assign max_x_c   = (max_x_ext > w_fx) ? w_fx : max_x_ext;
  assign max_y_c   = (max_y_ext > h_fx) ? h_fx : max_y_ext;
  assign min_x_c   = box_min_x_i[CoordW-1] ? '0 : box_min_x_i[CoordW-2:0];
  assign min_y_c   = box_min_y_i[CoordW-1] ? '0 : box_min_y_i[CoordW-2:0];
  assign max_x_m1  = max_x_c - 18'sd1;
  assign max_y_m1  = max_y_c - 18'sd1;

  // An empty box is dropped right here and never occupies the divider.
  assign box_live = ($signed({2'b00, min_x_c}) < max_x_c) &&
                    ($signed({2'b00, min_y_c}) < max_y_c);

  // --------------------------------------------------------------------------
  // Divider pipeline. Stage 0 holds the clipped dividends; each further stage
  // retires StepsPerStage quotient bits in all four lanes at once. The whole
  // pipeline moves together and freezes when the emitter cannot take a span.
  // --------------------------------------------------------------------------
  div_lane_t      lane_q [0:DivStages][Lanes];
  div_lane_t      lane_d [1:DivStages][Lanes];
  logic           valid_q [0:DivStages];
  logic [IdW-1:0] sid_q [0:DivStages];
  logic           advance;

  always_comb begin
    for (int s = 1; s <= DivStages; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        lane_d[s][l] = div_step(lane_q[s-1][l], divisor);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DivStages; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (advance) begin
      valid_q[0] <= in_valid_i && box_live;
      for (int s = 1; s <= DivStages; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lane_q[0][LaneFx] <= '{rem: '0, work: min_x_c[CoordW-2:FracBits]};
      lane_q[0][LaneLx] <= '{rem: '0, work: max_x_m1[CoordW-2:FracBits]};
      lane_q[0][LaneFy] <= '{rem: '0, work: min_y_c[CoordW-2:FracBits]};
      lane_q[0][LaneLy] <= '{rem: '0, work: max_y_m1[CoordW-2:FracBits]};
      sid_q[0]          <= splat_id_i;
      for (int s = 1; s <= DivStages; s++) begin
        lane_q[s] <= lane_d[s];
        sid_q[s]  <= sid_q[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Span check on the finished quotients. The last tile is clamped to the
  // grid; the image edge itself never pushes it past the tile count, so only
  // the grid limits matter. A box that starts beyond the clamped grid gives
  // no spans.
  // --------------------------------------------------------------------------
  logic [PixW-1:0] fx, lx, fy, ly;
  logic [ColW-1:0] lx_c;
  logic [RowW-1:0] ly_c;
  logic            span_ok, span_valid;

  assign fx = lane_q[DivStages][LaneFx].work;
  assign lx = lane_q[DivStages][LaneLx].work;
  assign fy = lane_q[DivStages][LaneFy].work;
  assign ly = lane_q[DivStages][LaneLy].work;

  assign lx_c = (lx > PixW'(LastColMax)) ? ColW'(LastColMax) : lx[ColW-1:0];
  assign ly_c = (ly > PixW'(LastRowMax)) ? RowW'(LastRowMax) : ly[RowW-1:0];

  assign span_ok    = (fx <= {{(PixW - ColW){1'b0}}, lx_c}) &&
                      (fy <= {{(PixW - RowW){1'b0}}, ly_c});
  assign span_valid = valid_q[DivStages] && span_ok;

  // --------------------------------------------------------------------------
  // Row emitter. It holds one span and walks its rows top to bottom. The
  // next span loads in the same cycle as the last row's transaction, so rows
  // of consecutive boxes follow without a gap.
  // --------------------------------------------------------------------------
  logic           busy_q, busy_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RowW-1:0] end_q, end_d;
  logic [ColW-1:0] first_q, first_d;
  logic [ColW-1:0] last_q, last_d;
  logic [IdW-1:0]  held_q, held_d;
  logic            last_row, load_ok, load, out_fire;

  assign last_row = (row_q == end_q);
  assign out_fire = busy_q && out_ready_i;
  assign load_ok  = !busy_q || (out_ready_i && last_row);
  assign load     = span_valid && load_ok;
  assign advance  = !(span_valid && !load_ok);

  always_comb begin
    busy_d  = busy_q;
    row_d   = row_q;
    end_d   = end_q;
    first_d = first_q;
    last_d  = last_q;
    held_d  = held_q;
    if (load) begin
      busy_d  = 1'b1;
      row_d   = fy[RowW-1:0];
      end_d   = ly_c;
      first_d = fx[ColW-1:0];
      last_d  = lx_c;
      held_d  = sid_q[DivStages];
    end else if (out_fire) begin
      if (last_row) begin
        busy_d = 1'b0;
      end else begin
        row_d = row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    end_q   <= end_d;
    first_q <= first_d;
    last_q  <= last_d;
    held_q  <= held_d;
  end

  assign in_ready_o  = advance;
  assign out_valid_o = busy_q;
  assign tile_row_o  = row_q;
  assign first_col_o = first_q;
  assign last_col_o  = last_q;
  assign splat_out_o = held_q;
  assign final_row_o = last_row;

endmodule
